@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define AST_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Condition that must never be seen outside reset.
`define AST_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);

`endif

@@ hw/rtl/rvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rvm_pkg;

	localparam int HEAP_BYTES  = 4096;
	localparam int STACK_BYTES = 4096;
	localparam int CALL_DEPTH  = 256;

	localparam int HEAP_AW     = $clog2(HEAP_BYTES);
	localparam int STACK_WORDS = STACK_BYTES / 8;
	localparam int SW_AW       = $clog2(STACK_WORDS);
	localparam int SP_W        = $clog2(STACK_BYTES + 1);
	localparam int RS_AW       = $clog2(CALL_DEPTH);
	localparam int RD_W        = $clog2(CALL_DEPTH + 1);
	localparam int CLR_N       = (HEAP_BYTES > STACK_WORDS) ? HEAP_BYTES : STACK_WORDS;
	localparam int CLR_W       = $clog2(CLR_N);

	localparam logic [4:0] OP_ADD   = 5'd0;
	localparam logic [4:0] OP_SUB   = 5'd1;
	localparam logic [4:0] OP_MUL   = 5'd2;
	localparam logic [4:0] OP_DIV   = 5'd3;
	localparam logic [4:0] OP_MOD   = 5'd4;
	localparam logic [4:0] OP_AND   = 5'd5;
	localparam logic [4:0] OP_OR    = 5'd6;
	localparam logic [4:0] OP_XOR   = 5'd7;
	localparam logic [4:0] OP_SHL   = 5'd8;
	localparam logic [4:0] OP_SHR   = 5'd9;
	localparam logic [4:0] OP_LOAD  = 5'd10;
	localparam logic [4:0] OP_STORE = 5'd11;
	localparam logic [4:0] OP_LDI   = 5'd12;
	localparam logic [4:0] OP_PUSH  = 5'd13;
	localparam logic [4:0] OP_POP   = 5'd14;
	localparam logic [4:0] OP_JMP   = 5'd15;
	localparam logic [4:0] OP_JZ    = 5'd16;
	localparam logic [4:0] OP_JNZ   = 5'd17;
	localparam logic [4:0] OP_JLT   = 5'd18;
	localparam logic [4:0] OP_JLE   = 5'd19;
	localparam logic [4:0] OP_JGT   = 5'd20;
	localparam logic [4:0] OP_JGE   = 5'd21;
	localparam logic [4:0] OP_CALL  = 5'd22;
	localparam logic [4:0] OP_RET   = 5'd23;
	localparam logic [4:0] OP_CMP   = 5'd24;
	localparam logic [4:0] OP_NOP   = 5'd25;
	localparam logic [4:0] OP_HALT  = 5'd26;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_DIVZ     = 4'd1;
	localparam logic [3:0] ST_MODZ     = 4'd2;
	localparam logic [3:0] ST_BOUNDS   = 4'd3;
	localparam logic [3:0] ST_OVER     = 4'd4;
	localparam logic [3:0] ST_UNDER    = 4'd5;
	localparam logic [3:0] ST_RETEMPTY = 4'd6;
	localparam logic [3:0] ST_BADOP    = 4'd7;
	localparam logic [3:0] ST_CALLFULL = 4'd8;

	localparam logic [3:0] FLAG_REG = 4'd15;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_MUL, S_DIV, S_LOAD, S_STORE, S_POP, S_RET, S_FIN
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
		logic [63:0] rem;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/rvm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rvm_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  cmd;
	logic [3:0]  dest_reg;
	logic [3:0]  src_a_reg;
	logic [3:0]  src_b_reg;
	logic [63:0] immediate;
	logic        begin_run;
	modport source (output valid, cmd, dest_reg, src_a_reg, src_b_reg, immediate, begin_run,
		input ready);
	modport sink (input valid, cmd, dest_reg, src_a_reg, src_b_reg, immediate, begin_run,
		output ready);
endinterface

interface rvm_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [15:0] next_pc;
	logic        halted;
	logic        reg_written;
	logic [3:0]  written_index;
	logic [63:0] written_value;
	modport source (output valid, status, next_pc, halted, reg_written, written_index,
		written_value, input ready);
	modport sink (input valid, status, next_pc, halted, reg_written, written_index,
		written_value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rvm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rvm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/rvm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rvm_div import rvm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q, rem_q, den_q;
	logic [64:0] rem_sh, diff;

	// restoring, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[63]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

@@ hw/rtl/register_vm_execute_unit_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Register VM execute unit: one instruction beat in, one result beat out. After reset the
// data and stack memories are swept to zero with req.ready low. One instruction is in flight
// at a time; ALU ops, jumps, push, call, cmp and nop pass through accept, register-file read
// and execute, and write-back; pop and ret add one extra memory read, mul adds three 32x32
// partial products through one multiplier, store and load move one byte per cycle (data
// memory is byte wide), and div and mod use a radix-2 divider, one quotient bit per cycle. A
// halted unit goes straight from execute to write-back. The result sits in an output register,
// so the write-back slot is only held up when the previous result beat has not been taken.
module register_vm_execute_unit_core import rvm_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	rvm_req_if.sink   req,
	rvm_rsp_if.source rsp
);
	`include "assert_macros.svh"

	state_t state_q, state_d, exec_nxt;

	// architectural state kept in flops
	logic [15:0]     pc_q;
	logic            halt_q;
	logic [SP_W-1:0] sp_q;
	logic [RD_W-1:0] rd_q;
	logic [15:0]     rv_q;          // register valid bits, clear reads as zero
	logic [CLR_W-1:0] clr_q;

	// captured instruction
	logic [4:0]  cmd_q;
	logic [3:0]  dst_q;
	logic [63:0] imm_q;
	logic        va_q, vb_q;
	logic [63:0] a_q, b_q;
	logic [HEAP_AW-1:0] ma_q;
	logic [3:0]  cnt_q;
	logic [63:0] prod_s1;

	// pending result
	logic [3:0]  res_st_q;
	logic [15:0] res_npc_q;
	logic        res_wr_q;
	logic [3:0]  res_widx_q;
	logic [63:0] res_wval_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  out_st_q;
	logic [15:0] out_npc_q;
	logic        out_halt_q;
	logic        out_wr_q;
	logic [3:0]  out_widx_q;
	logic [63:0] out_wval_q;

	logic accept, commit, clearing;
	logic [63:0] rf_a, rf_b, a, b;
	logic [7:0]  dm_rdata;
	logic [63:0] sm_rdata;
	logic [15:0] rs_rdata;
	logic [SP_W-1:0] sp_m8;
	logic [RD_W-1:0] rd_m1;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// execute-cycle decode
	logic [3:0]  ex_st;
	logic        ex_wr, ex_take, ex_push, ex_call, ex_halt;
	logic [3:0]  ex_widx;
	logic [63:0] ex_wval;
	logic [15:0] ex_npc;
	logic [31:0] mx, my;

	assign clearing = (state_q == S_CLEAR);
	assign accept   = req.valid && req.ready;
	assign commit   = (state_q == S_FIN) && (!out_valid_q || rsp.ready);
	assign a        = va_q ? rf_a : 64'd0;
	assign b        = vb_q ? rf_b : 64'd0;
	assign sp_m8    = sp_q - SP_W'(8);
	assign rd_m1    = rd_q - RD_W'(1);

	// two copies of the register file give two read ports
	rvm_ram #(.W(64), .D(16)) u_rf_a (
		.clk, .we(commit && res_wr_q), .waddr(res_widx_q), .wdata(res_wval_q),
		.raddr(req.src_a_reg), .rdata(rf_a));
	rvm_ram #(.W(64), .D(16)) u_rf_b (
		.clk, .we(commit && res_wr_q), .waddr(res_widx_q), .wdata(res_wval_q),
		.raddr(req.src_b_reg), .rdata(rf_b));

	rvm_ram #(.W(8), .D(HEAP_BYTES)) u_dmem (
		.clk,
		.we(clearing ? (clr_q < CLR_W'(HEAP_BYTES - 1) || clr_q == CLR_W'(HEAP_BYTES - 1))
			: (state_q == S_STORE)),
		.waddr(clearing ? clr_q[HEAP_AW-1:0] : ma_q + HEAP_AW'(cnt_q[2:0])),
		.wdata(clearing ? 8'd0 : b_q[7:0]),
		.raddr(ma_q + HEAP_AW'(cnt_q[2:0])),
		.rdata(dm_rdata));

	// stack pointer is always word aligned, so the stack is stored as words
	rvm_ram #(.W(64), .D(STACK_WORDS)) u_smem (
		.clk,
		.we(clearing ? (clr_q < CLR_W'(STACK_WORDS - 1) || clr_q == CLR_W'(STACK_WORDS - 1))
			: ((state_q == S_EXEC) && ex_push)),
		.waddr(clearing ? clr_q[SW_AW-1:0] : sp_q[SW_AW+2:3]),
		.wdata(clearing ? 64'd0 : a),
		.raddr(sp_m8[SW_AW+2:3]),
		.rdata(sm_rdata));

	// decode is only meaningful in S_EXEC, so the push and call writes are gated by it
	rvm_ram #(.W(16), .D(CALL_DEPTH)) u_rstk (
		.clk, .we((state_q == S_EXEC) && ex_call), .waddr(rd_q[RS_AW-1:0]), .wdata(pc_q),
		.raddr(rd_m1[RS_AW-1:0]), .rdata(rs_rdata));

	assign div_req.start = (state_q == S_EXEC) && (exec_nxt == S_DIV);
	assign div_req.num   = a;
	assign div_req.den   = b;

	rvm_div u_div (.clk, .arst_n, .req(div_req), .rsp(div_rsp));

	// execute decode, valid in S_EXEC while register data is on the RAM outputs
	always_comb begin
		ex_st    = ST_OK;
		ex_wr    = 1'b0;
		ex_widx  = dst_q;
		ex_wval  = 64'd0;
		ex_take  = 1'b0;
		ex_push  = 1'b0;
		ex_call  = 1'b0;
		ex_halt  = halt_q;
		exec_nxt = S_FIN;
		ex_npc   = pc_q + 16'd1;
		if (halt_q) begin
			ex_npc = pc_q;
		end else begin
			case (cmd_q)
				OP_ADD: begin ex_wr = 1'b1; ex_wval = a + b; end
				OP_SUB: begin ex_wr = 1'b1; ex_wval = a - b; end
				OP_MUL: begin ex_wr = 1'b1; exec_nxt = S_MUL; end
				OP_DIV, OP_MOD: begin
					if (b == 64'd0) begin
						ex_st = (cmd_q == OP_DIV) ? ST_DIVZ : ST_MODZ;
					end else begin
						ex_wr = 1'b1;
						exec_nxt = S_DIV;
					end
				end
				OP_AND: begin ex_wr = 1'b1; ex_wval = a & b; end
				OP_OR:  begin ex_wr = 1'b1; ex_wval = a | b; end
				OP_XOR: begin ex_wr = 1'b1; ex_wval = a ^ b; end
				OP_SHL: begin
					ex_wr = 1'b1;
					ex_wval = (b[63:6] != 58'd0) ? 64'd0 : (a << b[5:0]);
				end
				OP_SHR: begin
					ex_wr = 1'b1;
					ex_wval = (b[63:6] != 58'd0) ? 64'd0 : (a >> b[5:0]);
				end
				OP_LOAD, OP_STORE: begin
					if (a[31:0] > 32'(HEAP_BYTES - 8)) begin
						ex_st = ST_BOUNDS;
					end else if (cmd_q == OP_LOAD) begin
						ex_wr = 1'b1;
						exec_nxt = S_LOAD;
					end else begin
						exec_nxt = S_STORE;
					end
				end
				OP_LDI: begin ex_wr = 1'b1; ex_wval = imm_q; end
				OP_PUSH: begin
					if (sp_q > SP_W'(STACK_BYTES - 8)) ex_st = ST_OVER;
					else ex_push = 1'b1;
				end
				OP_POP: begin
					if (sp_q < SP_W'(8)) begin
						ex_st = ST_UNDER;
					end else begin
						ex_wr = 1'b1;
						exec_nxt = S_POP;
					end
				end
				OP_JMP: ex_take = 1'b1;
				OP_JZ:  ex_take = (a == 64'd0);
				OP_JNZ: ex_take = (a != 64'd0);
				OP_JLT: ex_take = ($signed(a) < $signed(b));
				OP_JLE: ex_take = ($signed(a) <= $signed(b));
				OP_JGT: ex_take = ($signed(a) > $signed(b));
				OP_JGE: ex_take = ($signed(a) >= $signed(b));
				OP_CALL: begin
					if (rd_q == RD_W'(CALL_DEPTH)) begin
						ex_st = ST_CALLFULL;
					end else begin
						ex_call = 1'b1;
						ex_take = 1'b1;
					end
				end
				OP_RET: begin
					if (rd_q == '0) ex_st = ST_RETEMPTY;
					else exec_nxt = S_RET;
				end
				OP_CMP: begin
					ex_wr = 1'b1;
					ex_widx = FLAG_REG;
					ex_wval = (a == b) ? 64'd0 : (($signed(a) < $signed(b)) ? 64'd1 : 64'd2);
				end
				OP_NOP: ;
				OP_HALT: ex_halt = 1'b1;
				default: ex_st = ST_BADOP;
			endcase
			if (ex_st != ST_OK) begin
				ex_wr    = 1'b0;
				ex_npc   = pc_q;
				exec_nxt = S_FIN;
			end else if (ex_take) begin
				ex_npc = imm_q[15:0];
			end
		end
	end

	// one shared 32x32 multiplier: al*bl, al*bh, ah*bl
	assign mx = (cnt_q == 4'd2) ? a_q[63:32] : a_q[31:0];
	assign my = (cnt_q == 4'd1) ? b_q[63:32] : b_q[31:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == CLR_W'(CLR_N - 1)) state_d = S_IDLE;
			S_IDLE:  if (accept) state_d = S_EXEC;
			S_EXEC:  state_d = exec_nxt;
			S_MUL:   if (cnt_q == 4'd3) state_d = S_FIN;
			S_DIV:   if (div_rsp.done) state_d = S_FIN;
			S_LOAD:  if (cnt_q == 4'd8) state_d = S_FIN;
			S_STORE: if (cnt_q == 4'd7) state_d = S_FIN;
			S_POP, S_RET: state_d = S_FIN;
			S_FIN:   if (commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready         = (state_q == S_IDLE);
		rsp.valid         = out_valid_q;
		rsp.status        = out_st_q;
		rsp.next_pc       = out_npc_q;
		rsp.halted        = out_halt_q;
		rsp.reg_written   = out_wr_q;
		rsp.written_index = out_widx_q;
		rsp.written_value = out_wval_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			sp_q        <= '0;
			rd_q        <= '0;
			rv_q        <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + CLR_W'(1);
			// a new result replaces the one being taken in the same cycle
			if (commit) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && req.begin_run) begin
						pc_q   <= '0;
						halt_q <= 1'b0;
					end
				end
				S_EXEC: begin
					cnt_q  <= '0;
					halt_q <= ex_halt;
					if (ex_push) sp_q <= sp_q + SP_W'(8);
					if (exec_nxt == S_POP) sp_q <= sp_m8;
					if (ex_call) rd_q <= rd_q + RD_W'(1);
					if (exec_nxt == S_RET) rd_q <= rd_m1;
				end
				S_MUL, S_LOAD, S_STORE: cnt_q <= cnt_q + 4'd1;
				S_FIN: begin
					if (commit) begin
						pc_q <= res_npc_q;
						if (res_wr_q) rv_q[res_widx_q] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= req.cmd;
					dst_q <= req.dest_reg;
					imm_q <= req.immediate;
					va_q  <= rv_q[req.src_a_reg];
					vb_q  <= rv_q[req.src_b_reg];
				end
			end
			S_EXEC: begin
				a_q        <= a;
				b_q        <= b;
				ma_q       <= a[HEAP_AW-1:0];
				res_st_q   <= ex_st;
				res_npc_q  <= ex_npc;
				res_wr_q   <= ex_wr;
				res_widx_q <= ex_wr ? ex_widx : 4'd0;
				res_wval_q <= ex_wval;
			end
			S_MUL: begin
				if (cnt_q != 4'd3) prod_s1 <= mx * my;
				if (cnt_q == 4'd1) res_wval_q <= prod_s1;
				else if (cnt_q != 4'd0) res_wval_q <= res_wval_q + {prod_s1[31:0], 32'd0};
			end
			S_DIV: if (div_rsp.done) res_wval_q <= (cmd_q == OP_DIV) ? div_rsp.quo : div_rsp.rem;
			// bytes arrive low first and shift down into place
			S_LOAD: if (cnt_q != 4'd0) res_wval_q <= {dm_rdata, res_wval_q[63:8]};
			S_STORE: b_q <= {8'd0, b_q[63:8]};
			S_POP: res_wval_q <= sm_rdata;
			S_RET: res_npc_q <= rs_rdata + 16'd1;
			S_FIN: begin
				if (commit) begin
					out_st_q   <= res_st_q;
					out_npc_q  <= res_npc_q;
					out_halt_q <= halt_q;
					out_wr_q   <= res_wr_q;
					out_widx_q <= res_widx_q;
					out_wval_q <= res_wval_q;
				end
			end
			default: ;
		endcase
	end

	`AST_HOLDS(a_accept_exec, accept |=> (state_q == S_EXEC), "accepted beat not executed")
	`AST_NEVER(a_rd_range, rd_q > RD_W'(CALL_DEPTH), "return depth beyond call depth")
	`AST_NEVER(a_sp_align, (sp_q[2:0] != 3'd0) || (sp_q > SP_W'(STACK_BYTES)),
		"stack pointer misaligned or out of range")
	`AST_NEVER(a_fault_nowrite, rsp.valid && rsp.reg_written && (rsp.status != ST_OK),
		"faulting result reports a register write")
endmodule
`default_nettype wire
